// ===== sv/lcgrs_pkg.sv =====
package lcgrs_pkg;

    // Default sizes handed to the top level
    localparam int STREAM_BITS_DEF = 31;
    localparam int QUEUE_DEPTH_DEF = 4;

    // 5^27; only the low 31 bits matter for any modulus up to 2^31
    localparam logic [63:0] LCG_MULT   = 64'd7450580596923828125;
    localparam logic [30:0] LCG_MULT31 = LCG_MULT[30:0];

    // Command codes on the request channel
    localparam logic [1:0] CMD_DRAW = 2'd0;
    localparam logic [1:0] CMD_BERN = 2'd1;
    localparam logic [1:0] CMD_RINT = 2'd2;

    // Work class decided by the front end
    typedef enum logic [1:0] {
        OP_PASS,
        OP_DRAW,
        OP_BERN,
        OP_RINT
    } t_op;

    // Classified request as it sits in the queue
    typedef struct packed {
        t_op         op;
        logic        anti;
        logic [30:0] mag;
        logic [31:0] stream;
        logic [30:0] prob;
        logic [31:0] lo;
        logic [32:0] span;
        logic        ival_pre;
        logic        err;
    } t_item;

endpackage

// ===== sv/lcg_random_stream_draw.sv =====
// Random stream draw: multiplicative generator x * 5^27 mod 2^STREAM_BITS.
// Request channel: i_valid / o_stall with command, stream, probability and
// bounds; a request is taken at a clock edge with i_valid high, o_stall low.
// Result channel: o_valid / i_stall with the new stream, the Q0.31 fraction,
// the Bernoulli bit or range integer, and the reversed-bounds error flag.
// Every request gives exactly one result, in request order.
// The generator multiply, the span multiply and the output register each
// take one stage.
// Throughput: one request per cycle while i_stall is low, set by the
// single-stage 31x31 and 31x32 multipliers.
// A QUEUE_DEPTH-entry queue sits between the classifying front end and the
// arithmetic pipe. While o_valid and i_stall are high the whole pipe holds and
// the result stays put; requests keep filling the queue until it is full,
// which raises o_stall. Reset (synchronous, active low) empties the queue and the pipe.
module lcg_random_stream_draw #(
    parameter int STREAM_BITS = lcgrs_pkg::STREAM_BITS_DEF,
    parameter int QUEUE_DEPTH = lcgrs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic        [1:0]  i_command,
    input  logic signed [31:0] i_stream_in,
    input  logic        [31:0] i_probability,
    input  logic signed [31:0] i_low_bound,
    input  logic signed [31:0] i_high_bound,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_stream_out,
    output logic        [30:0] o_fraction,
    output logic signed [31:0] o_int_value,
    output logic               o_error_code
);

    lcgrs_pkg::t_item w_front_item;
    lcgrs_pkg::t_item w_q_item;
    logic             w_push;
    logic             w_pop;
    logic             w_q_valid;

    assign w_push = i_valid && !o_stall;

    // Front end: classify the request
    lcgrs_front u_front (
        .i_command     (i_command),
        .i_stream_in   (i_stream_in),
        .i_probability (i_probability),
        .i_low_bound   (i_low_bound),
        .i_high_bound  (i_high_bound),
        .o_item        (w_front_item)
    );

    // Decoupling queue
    lcgrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (o_stall),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    // Arithmetic pipe
    lcgrs_back #(
        .STREAM_BITS (STREAM_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_item     (w_q_item),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_stream_out (o_stream_out),
        .o_fraction   (o_fraction),
        .o_int_value  (o_int_value),
        .o_error_code (o_error_code)
    );

    // Reversed bounds never carry a drawn value
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code |-> o_fraction == '0 && o_int_value == '0)
        else $error("error result carries a drawn value");

    // A held result freezes the pipe, so nothing leaves the queue
    a_hold_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> !w_pop)
        else $error("queue popped while result stalled");

    // A request taken into an empty queue is visible next cycle
    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_q_valid |=> w_q_valid)
        else $error("accepted request lost in queue");

endmodule

// ===== sv/lcgrs_front.sv =====
module lcgrs_front (
    input  logic               [1:0]  i_command,
    input  logic signed        [31:0] i_stream_in,
    input  logic               [31:0] i_probability,
    input  logic signed        [31:0] i_low_bound,
    input  logic signed        [31:0] i_high_bound,
    output lcgrs_pkg::t_item          o_item
);

    logic [32:0] w_diff;
    logic [31:0] w_neg;

    // high - low in 33 bits: sign gives reversed bounds, +1 gives the span
    assign w_diff = {i_high_bound[31], i_high_bound} - {i_low_bound[31], i_low_bound};
    assign w_neg  = 32'd0 - i_stream_in;

    // Classify the request
    always_comb begin
        o_item.anti     = i_stream_in[31];
        o_item.mag      = i_stream_in[31] ? w_neg[30:0] : i_stream_in[30:0];
        o_item.stream   = i_stream_in;
        o_item.prob     = i_probability[30:0];
        o_item.lo       = i_low_bound;
        o_item.span     = w_diff + 33'd1;
        o_item.ival_pre = 1'b0;
        o_item.err      = 1'b0;
        o_item.op       = lcgrs_pkg::OP_PASS;
        unique case (i_command)
            lcgrs_pkg::CMD_DRAW: begin
                o_item.op = lcgrs_pkg::OP_DRAW;
            end
            lcgrs_pkg::CMD_BERN: begin
                // certain or impossible: no draw
                if (i_probability[31]) begin
                    o_item.ival_pre = 1'b1;
                end else if (i_probability[30:0] != 31'd0) begin
                    o_item.op = lcgrs_pkg::OP_BERN;
                end
            end
            lcgrs_pkg::CMD_RINT: begin
                if (w_diff[32]) begin
                    o_item.err = 1'b1;
                end else begin
                    o_item.op = lcgrs_pkg::OP_RINT;
                end
            end
            default: begin
                o_item.op = lcgrs_pkg::OP_PASS;
            end
        endcase
    end

endmodule

// ===== sv/lcgrs_queue.sv =====
module lcgrs_queue #(
    parameter int DEPTH = lcgrs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lcgrs_pkg::t_item i_item,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output lcgrs_pkg::t_item o_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lcgrs_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== sv/lcgrs_back.sv =====
module lcgrs_back #(
    parameter int STREAM_BITS = lcgrs_pkg::STREAM_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_valid,
    input  lcgrs_pkg::t_item         i_q_item,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed       [31:0] o_stream_out,
    output logic              [30:0] o_fraction,
    output logic signed       [31:0] o_int_value,
    output logic                     o_error_code
);

    localparam logic [30:0] MOD_MASK = 31'((64'd1 << STREAM_BITS) - 64'd1);
    localparam int          U_SHIFT  = 31 - STREAM_BITS;

    logic w_en;

    // stage A: generator step
    logic             r_a_valid;
    lcgrs_pkg::t_item r_a_item;
    logic [30:0]      r_a_next;
    logic [61:0]      w_a_prod;

    // stage B: fraction and span product
    logic             r_b_valid;
    lcgrs_pkg::t_op   r_b_op;
    logic [31:0]      r_b_stream;
    logic [30:0]      r_b_frac;
    logic             r_b_ival;
    logic             r_b_err;
    logic [62:0]      r_b_prod;
    logic             r_b_span32;
    logic [31:0]      r_b_lo;

    logic [30:0]      w_u;
    logic [30:0]      w_frac;
    logic [31:0]      w_new_stream;
    logic [31:0]      n_b_stream;
    logic [30:0]      n_b_frac;
    logic             n_b_ival;
    logic [62:0]      w_b_prod;

    // stage C: output register
    logic [31:0]      w_off;
    logic [31:0]      n_c_ival;

    // Whole pipe moves when the output slot is free or being taken
    assign w_en  = !o_valid || !i_stall;
    assign o_pop = w_en;

    // Stage A: magnitude * 5^27 mod 2^STREAM_BITS
    assign w_a_prod = {31'd0, i_q_item.mag} * {31'd0, lcgrs_pkg::LCG_MULT31};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_item <= i_q_item;
            r_a_next <= w_a_prod[30:0] & MOD_MASK;
        end
    end

    // Stage B: Q0.31 fraction, antithetic fold, Bernoulli compare
    always_comb begin
        w_u          = r_a_next << U_SHIFT;
        w_frac       = r_a_item.anti ? (31'd0 - w_u) : w_u;
        w_new_stream = r_a_item.anti ? (32'd0 - {1'b0, r_a_next}) : {1'b0, r_a_next};
        w_b_prod     = {32'd0, w_frac} * {31'd0, r_a_item.span[31:0]};
        n_b_stream   = w_new_stream;
        n_b_frac     = w_frac;
        n_b_ival     = 1'b0;
        case (r_a_item.op)
            lcgrs_pkg::OP_PASS: begin
                n_b_stream = r_a_item.stream;
                n_b_frac   = 31'd0;
                n_b_ival   = r_a_item.ival_pre;
            end
            lcgrs_pkg::OP_BERN: n_b_ival = (w_frac < r_a_item.prob);
            default:            n_b_ival = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_op     <= r_a_item.op;
            r_b_stream <= n_b_stream;
            r_b_frac   <= n_b_frac;
            r_b_ival   <= n_b_ival;
            r_b_err    <= r_a_item.err;
            r_b_prod   <= w_b_prod;
            r_b_span32 <= r_a_item.span[32];
            r_b_lo     <= r_a_item.lo;
        end
    end

    // Stage C: low + floor(u * span); a full 2^32 span has zero low word
    always_comb begin
        w_off    = r_b_span32 ? {r_b_frac, 1'b0} : r_b_prod[62:31];
        n_c_ival = (r_b_op == lcgrs_pkg::OP_RINT) ? (r_b_lo + w_off) : {31'd0, r_b_ival};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_stream_out <= r_b_stream;
            o_fraction   <= r_b_frac;
            o_int_value  <= n_c_ival;
            o_error_code <= r_b_err;
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            o_valid   <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_q_valid;
            r_b_valid <= r_a_valid;
            o_valid   <= r_b_valid;
        end
    end

endmodule
